/* rtl/lbsp_pkg.sv */
// Shared types, constants and build-time table functions for the log band
// spectrum peak-hold block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbsp_pkg;

   // Fixed field widths
   localparam int MAG_W    = 24;
   localparam int POS_W    = 12;
   localparam int CNT_W    = 10;
   localparam int SUM_W    = 34;   // 1023 bins of 24 bits
   localparam int LVL_W    = 16;
   localparam int HOLD_W   = 8;
   localparam int IDX_W    = 6;
   localparam int CSR_A_W  = 3;
   localparam int CSR_D_W  = 16;
   localparam int MAX_BANDS = 64;

   // Arithmetic unit widths
   localparam int ALU_A_W  = 50;
   localparam int ALU_B_W  = 35;
   localparam int PROD_W   = 58;
   localparam int QUO_BITS = 15;
   localparam int DIV_CNT_W = 4;

   localparam logic [POS_W-1:0]  POS_MAX    = 12'd4095;
   localparam logic [CNT_W-1:0]  COUNT_MAX  = 10'd1023;
   localparam logic [LVL_W-1:0]  FULL_SCALE = 16'd32768;
   localparam logic [23:0]       SCALE_DIV  = 24'd10000000;
   localparam int                GATE_BIN   = 5;
   localparam int                MIN_HZ     = 100;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_GAIN       = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_NOISE_GATE = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_SMOOTH     = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_HOLD       = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_FALL       = 3'd4;

   typedef enum logic [0:0] {
      ALU_MUL,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type         op;
      logic [ALU_A_W-1:0] a;
      logic [ALU_B_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [PROD_W-1:0]  prod;
      logic [ALU_A_W-1:0] diff;
      logic               borrow;
   } alu_rsp_type;

   // One band entry of one channel
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  cnt;
      logic [LVL_W-1:0]  lvl;
      logic [LVL_W-1:0]  pk;
      logic [HOLD_W-1:0] hold;
   } band_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK,
      ST_ACC,
      ST_WRD,
      ST_WLOAD,
      ST_WQMUL,
      ST_WCMP,
      ST_WDIV,
      ST_WGATE,
      ST_WSM1,
      ST_WSM2,
      ST_WFIN
   } seq_state_type;

   // First bin of each band; unused bands hold FFT_POINTS/2
   typedef logic [MAX_BANDS-1:0][POS_W-1:0] start_table_type;

   // log2 in Q30 by repeated squaring, truncated
   function automatic logic [63:0] log2_q30(input logic [31:0] x);
      int          e;
      logic [63:0] m;
      logic [63:0] res;
      int          bitn;
      e = 31;
      m = '0;
      res = '0;
      if (x != 32'd0) begin
         while (x[e] == 1'b0) e = e - 1;
         if (e <= 30) m = 64'(x) << (30 - e);
         else m = 64'(x >> (e - 30));
         res = 64'(e) << 30;
         for (bitn = 29; bitn >= 0; bitn--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               res[bitn] = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Band b starts at the first used bin i with (a-lo)*bands >= b*(c-d)
   function automatic start_table_type bin_start_table(input int bands, input int points,
                                                       input int rate);
      start_table_type t;
      int              half;
      int              i;
      int              bb;
      logic [31:0]     fi;
      logic [63:0]     a;
      logic [63:0]     lo;
      logic [63:0]     c;
      logic [63:0]     d;
      logic [63:0]     num;
      logic [63:0]     den;
      half = points >> 1;
      for (bb = 0; bb < MAX_BANDS; bb++) t[bb] = POS_W'(half);
      lo = log2_q30(32'(MIN_HZ * points));
      c  = log2_q30(32'(rate >> 1));
      d  = log2_q30(32'(MIN_HZ));
      den = c - d;
      for (i = 0; i < half; i++) begin
         fi = 32'(i * rate);
         if (i >= GATE_BIN && fi >= 32'(MIN_HZ * points)) begin
            a = log2_q30(fi);
            if (t[0] == POS_W'(half)) t[0] = POS_W'(i);
            if (c > d && a > lo) begin
               num = (a - lo) * 64'(bands);
               for (bb = 1; bb < bands; bb++) begin
                  if (t[bb] == POS_W'(half) && num >= den * 64'(bb)) t[bb] = POS_W'(i);
               end
            end
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

/* rtl/lbsp_if.sv */
// Valid/ready channel interfaces for bin items and band result items.
// Depends on lbsp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lbsp_req_if;
   logic                         valid;
   logic                         ready;
   logic                         channel;
   logic [lbsp_pkg::MAG_W-1:0]   magnitude;
   logic                         frame_end;

   modport source(output valid, channel, magnitude, frame_end, input ready);
   modport sink(input valid, channel, magnitude, frame_end, output ready);
endinterface

interface lbsp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         out_channel;
   logic [lbsp_pkg::IDX_W-1:0]   band_index;
   logic [lbsp_pkg::LVL_W-1:0]   level;
   logic [lbsp_pkg::LVL_W-1:0]   peak_level;
   logic                         last_band;

   modport source(output valid, out_channel, band_index, level, peak_level, last_band,
                  input ready);
   modport sink(input valid, out_channel, band_index, level, peak_level, last_band,
                output ready);
endinterface

`default_nettype wire

/* rtl/lbsp_alu.sv */
// Shared arithmetic unit: one multiplier and one subtractor with borrow.
// Depends on lbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbsp_alu (
   input  lbsp_pkg::alu_req_type req,
   output lbsp_pkg::alu_rsp_type rsp
);

   logic [lbsp_pkg::ALU_A_W:0] diff_full;

   // 34 x 24 product; operands are narrow enough for both uses
   always_comb begin
      diff_full = {1'b0, req.a} - {{(lbsp_pkg::ALU_A_W + 1 - lbsp_pkg::ALU_B_W){1'b0}}, req.b};
      rsp.prod  = '0;
      rsp.diff  = '0;
      rsp.borrow = 1'b0;
      unique case (req.op)
         lbsp_pkg::ALU_MUL: begin
            rsp.prod = lbsp_pkg::PROD_W'(req.a[lbsp_pkg::SUM_W-1:0]) *
                       lbsp_pkg::PROD_W'(req.b[23:0]);
         end
         lbsp_pkg::ALU_SUB: begin
            rsp.diff   = diff_full[lbsp_pkg::ALU_A_W-1:0];
            rsp.borrow = diff_full[lbsp_pkg::ALU_A_W];
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lbsp_band_mem.sv */
// Per-channel per-band state memory with registered read and reset-cleared
// valid bits; an entry never written reads as zero. Depends on lbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbsp_band_mem #(
   parameter int ADDR_W = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          rd_en,
   input  wire  [ADDR_W-1:0]            rd_addr,
   input  wire                          wr_en,
   input  wire  [ADDR_W-1:0]            wr_addr,
   input  lbsp_pkg::band_word_type      wr_data,
   output lbsp_pkg::band_word_type      rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   lbsp_pkg::band_word_type mem [DEPTH];
   logic [DEPTH-1:0]        valid_ff;
   lbsp_pkg::band_word_type rd_word_ff;
   logic                    rd_valid_ff;

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_word_ff <= mem[rd_addr];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

/* rtl/log_band_spectrum_peak_hold.sv */
// Log band spectrum analyzer with peak hold: top level with sequencer.
// Depends on lbsp_pkg, lbsp_if, lbsp_alu and lbsp_band_mem.
//
// Usage: feed FFT magnitude bins on req_bus, one bin per item, tagged with
// the channel and frame_end on the last bin of that channel's frame. The
// bin index is counted internally per channel. On a frame_end item the
// block emits BANDS result items on rsp_bus in band order, last_band set on
// the final one, then starts that channel's next frame from bin zero.
// Steps: accept, table seek (repeated per band boundary crossed) and memory
// read-modify-write; a skipped bin ends after the seek. The frame-end walk
// takes each band through read, gain and count products, compare, restoring
// divide (non-empty, below full scale), gate, two smoothing products and
// write-back, all on the one shared multiplier/subtractor. req_bus.ready is
// high only while the sequencer is idle. One result register sits on rsp_bus;
// a stalled receiver holds the walk at the band that waits, and the next bin
// may still be accepted once the walk is done. Synchronous reset clears all
// band state (through valid bits), bin counters and registers to their
// defaults at once. csr_* writes are taken at once; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module log_band_spectrum_peak_hold #(
   parameter int BANDS          = 32,
   parameter int FFT_POINTS     = 1024,
   parameter int SAMPLE_RATE_HZ = 44100
) (
   input  wire                               clock,
   input  wire                               reset,
   lbsp_req_if.sink                          req_bus,
   lbsp_rsp_if.source                        rsp_bus,
   input  wire                               csr_we,
   input  wire  [lbsp_pkg::CSR_A_W-1:0]      csr_index,
   input  wire  [lbsp_pkg::CSR_D_W-1:0]      csr_wdata
);

   localparam int BW     = $clog2(BANDS);
   localparam int AW     = BW + 1;
   localparam logic [lbsp_pkg::POS_W-1:0] HALF = lbsp_pkg::POS_W'(FFT_POINTS / 2);
   localparam logic [BW-1:0] LAST_BAND = BW'(BANDS - 1);
   localparam lbsp_pkg::start_table_type START_TBL =
      lbsp_pkg::bin_start_table(BANDS, FFT_POINTS, SAMPLE_RATE_HZ);

   // registers
   lbsp_pkg::seq_state_type         state_ff, state_in;
   logic                            ch_ff, ch_in;
   logic [lbsp_pkg::MAG_W-1:0]      mag_ff, mag_in;
   logic                            fend_ff, fend_in;
   logic [lbsp_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [lbsp_pkg::POS_W-1:0]      bin_pos_ff [2];
   logic [lbsp_pkg::POS_W-1:0]      bin_pos_in [2];
   logic [BW-1:0]                   cur_band_ff [2];
   logic [BW-1:0]                   cur_band_in [2];
   logic [BW-1:0]                   k_ff, k_in;
   logic [lbsp_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   lbsp_pkg::band_word_type         word_ff, word_in;
   logic [lbsp_pkg::ALU_A_W-1:0]    p_ff, p_in;
   logic [lbsp_pkg::SUM_W-1:0]      q_ff, q_in;
   logic [lbsp_pkg::SUM_W-1:0]      r_ff, r_in;
   logic [lbsp_pkg::QUO_BITS-1:0]   quo_ff, quo_in;
   logic [lbsp_pkg::LVL_W-1:0]      v_ff, v_in;
   logic [32:0]                     acc_ff, acc_in;

   logic [lbsp_pkg::CSR_D_W-1:0]    gain_ff, noise_gate_ff, smooth_ff, fall_ff;
   logic [lbsp_pkg::HOLD_W-1:0]     hold_frames_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ch_ff, rsp_ch_in;
   logic [lbsp_pkg::IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [lbsp_pkg::LVL_W-1:0]      rsp_lvl_ff, rsp_lvl_in;
   logic [lbsp_pkg::LVL_W-1:0]      rsp_pk_ff, rsp_pk_in;
   logic                            rsp_last_ff, rsp_last_in;

   // datapath hookups
   lbsp_pkg::alu_req_type           alu_req;
   lbsp_pkg::alu_rsp_type           alu_rsp;
   logic                            rd_en, wr_en;
   logic [AW-1:0]                   rd_addr, wr_addr;
   lbsp_pkg::band_word_type         wr_data, rd_data;

   logic [BW-1:0]                   cur;
   logic                            bin_ok;
   logic                            out_free;
   logic [lbsp_pkg::SUM_W:0]        r2;
   logic [lbsp_pkg::LVL_W-1:0]      pk_new;
   logic [lbsp_pkg::HOLD_W-1:0]     hold_new;

   lbsp_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   lbsp_band_mem #(.ADDR_W(AW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req_bus.ready       = (state_ff == lbsp_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.band_index  = rsp_idx_ff;
   assign rsp_bus.level       = rsp_lvl_ff;
   assign rsp_bus.peak_level  = rsp_pk_ff;
   assign rsp_bus.last_band   = rsp_last_ff;

   assign cur      = cur_band_ff[ch_ff];
   assign bin_ok   = (pos_ff >= START_TBL[0]) && (pos_ff < HALF);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign r2       = {r_ff, 1'b0};

   // peak hold with linear fall
   always_comb begin
      pk_new   = word_ff.pk;
      hold_new = word_ff.hold;
      priority if (word_ff.lvl > word_ff.pk) begin
         pk_new   = word_ff.lvl;
         hold_new = hold_frames_ff;
      end else if (word_ff.hold != '0) begin
         hold_new = word_ff.hold - 1'b1;
      end else if (word_ff.pk > fall_ff) begin
         pk_new = word_ff.pk - fall_ff;
      end else begin
         pk_new = '0;
      end
   end

   // sequencer: next state, unit operands, memory controls
   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      mag_in     = mag_ff;
      fend_in    = fend_ff;
      pos_in     = pos_ff;
      bin_pos_in = bin_pos_ff;
      cur_band_in = cur_band_ff;
      k_in       = k_ff;
      div_cnt_in = div_cnt_ff;
      word_in    = word_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      quo_in     = quo_ff;
      v_in       = v_ff;
      acc_in     = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ch_in  = rsp_ch_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_lvl_in = rsp_lvl_ff;
      rsp_pk_in  = rsp_pk_ff;
      rsp_last_in = rsp_last_ff;
      alu_req    = '{op: lbsp_pkg::ALU_MUL, a: '0, b: '0};
      rd_en      = 1'b0;
      rd_addr    = {ch_ff, cur};
      wr_en      = 1'b0;
      wr_addr    = {ch_ff, k_ff};
      wr_data    = word_ff;

      unique case (state_ff)
         lbsp_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               ch_in   = req_bus.channel;
               mag_in  = req_bus.magnitude;
               fend_in = req_bus.frame_end;
               pos_in  = bin_pos_ff[req_bus.channel];
               if (req_bus.frame_end) begin
                  bin_pos_in[req_bus.channel] = '0;
               end else if (bin_pos_ff[req_bus.channel] < lbsp_pkg::POS_MAX) begin
                  bin_pos_in[req_bus.channel] = bin_pos_ff[req_bus.channel] + 1'b1;
               end
               state_in = lbsp_pkg::ST_SEEK;
            end
         end
         // advance the running band until the bin falls inside it, or skip a bin outside the used range
         lbsp_pkg::ST_SEEK: begin
            priority if (!bin_ok) begin
               k_in = '0;
               if (fend_ff) begin
                  cur_band_in[ch_ff] = '0;
                  state_in = lbsp_pkg::ST_WRD;
               end else begin
                  state_in = lbsp_pkg::ST_IDLE;
               end
            end else if (cur != LAST_BAND &&
                         pos_ff >= START_TBL[lbsp_pkg::IDX_W'(cur) + 6'd1]) begin
               cur_band_in[ch_ff] = cur + 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = {ch_ff, cur};
               state_in = lbsp_pkg::ST_ACC;
            end
         end
         lbsp_pkg::ST_ACC: begin
            wr_addr = {ch_ff, cur};
            wr_data = rd_data;
            wr_data.sum = rd_data.sum + lbsp_pkg::SUM_W'(mag_ff);
            wr_data.cnt = rd_data.cnt + 1'b1;
            wr_en = (rd_data.cnt < lbsp_pkg::COUNT_MAX);
            k_in  = '0;
            if (fend_ff) begin
               cur_band_in[ch_ff] = '0;
               state_in = lbsp_pkg::ST_WRD;
            end else begin
               state_in = lbsp_pkg::ST_IDLE;
            end
         end
         // frame-end walk, one band at a time
         lbsp_pkg::ST_WRD: begin
            rd_en    = 1'b1;
            rd_addr  = {ch_ff, k_ff};
            state_in = lbsp_pkg::ST_WLOAD;
         end
         lbsp_pkg::ST_WLOAD: begin
            word_in  = rd_data;
            alu_req  = '{op: lbsp_pkg::ALU_MUL, a: lbsp_pkg::ALU_A_W'(rd_data.sum),
                         b: lbsp_pkg::ALU_B_W'(gain_ff)};
            p_in     = alu_rsp.prod[lbsp_pkg::ALU_A_W-1:0];
            state_in = lbsp_pkg::ST_WQMUL;
         end
         lbsp_pkg::ST_WQMUL: begin
            alu_req  = '{op: lbsp_pkg::ALU_MUL, a: lbsp_pkg::ALU_A_W'(word_ff.cnt),
                         b: lbsp_pkg::ALU_B_W'(lbsp_pkg::SCALE_DIV)};
            q_in     = alu_rsp.prod[lbsp_pkg::SUM_W-1:0];
            state_in = lbsp_pkg::ST_WCMP;
         end
         // zero for an empty band, saturate at full scale, else divide
         lbsp_pkg::ST_WCMP: begin
            alu_req = '{op: lbsp_pkg::ALU_SUB, a: p_ff, b: lbsp_pkg::ALU_B_W'(q_ff)};
            r_in       = p_ff[lbsp_pkg::SUM_W-1:0];
            quo_in     = '0;
            div_cnt_in = '0;
            priority if (word_ff.cnt == '0) begin
               v_in     = '0;
               state_in = lbsp_pkg::ST_WGATE;
            end else if (!alu_rsp.borrow) begin
               v_in     = lbsp_pkg::FULL_SCALE;
               state_in = lbsp_pkg::ST_WGATE;
            end else begin
               state_in = lbsp_pkg::ST_WDIV;
            end
         end
         // restoring divide, one quotient bit a cycle
         lbsp_pkg::ST_WDIV: begin
            alu_req = '{op: lbsp_pkg::ALU_SUB, a: lbsp_pkg::ALU_A_W'(r2),
                        b: lbsp_pkg::ALU_B_W'(q_ff)};
            r_in   = alu_rsp.borrow ? r2[lbsp_pkg::SUM_W-1:0]
                                    : alu_rsp.diff[lbsp_pkg::SUM_W-1:0];
            quo_in = {quo_ff[lbsp_pkg::QUO_BITS-2:0], !alu_rsp.borrow};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == lbsp_pkg::DIV_CNT_W'(lbsp_pkg::QUO_BITS - 1)) begin
               v_in     = {1'b0, quo_in};
               state_in = lbsp_pkg::ST_WGATE;
            end
         end
         lbsp_pkg::ST_WGATE: begin
            if (v_ff < noise_gate_ff) v_in = '0;
            state_in = lbsp_pkg::ST_WSM1;
         end
         // exponential smoothing, two products
         lbsp_pkg::ST_WSM1: begin
            alu_req  = '{op: lbsp_pkg::ALU_MUL, a: lbsp_pkg::ALU_A_W'(word_ff.lvl),
                         b: lbsp_pkg::ALU_B_W'(smooth_ff)};
            acc_in   = alu_rsp.prod[32:0];
            state_in = lbsp_pkg::ST_WSM2;
         end
         lbsp_pkg::ST_WSM2: begin
            alu_req  = '{op: lbsp_pkg::ALU_MUL, a: lbsp_pkg::ALU_A_W'(v_ff),
                         b: lbsp_pkg::ALU_B_W'(17'h10000 - {1'b0, smooth_ff})};
            acc_in   = acc_ff + alu_rsp.prod[32:0] + 33'd32768;
            word_in.lvl = acc_in[31:16];
            state_in = lbsp_pkg::ST_WFIN;
         end
         // write back, clear the sums, hand out the band
         lbsp_pkg::ST_WFIN: begin
            if (out_free) begin
               wr_en   = 1'b1;
               wr_addr = {ch_ff, k_ff};
               wr_data = '{sum: '0, cnt: '0, lvl: word_ff.lvl, pk: pk_new, hold: hold_new};
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_idx_in   = lbsp_pkg::IDX_W'(k_ff);
               rsp_lvl_in   = word_ff.lvl;
               rsp_pk_in    = pk_new;
               rsp_last_in  = (k_ff == LAST_BAND);
               if (k_ff == LAST_BAND) begin
                  state_in = lbsp_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = lbsp_pkg::ST_WRD;
               end
            end
         end
         default: state_in = lbsp_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbsp_pkg::ST_IDLE;
         bin_pos_ff   <= '{default: '0};
         cur_band_ff  <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bin_pos_ff   <= bin_pos_in;
         cur_band_ff  <= cur_band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      mag_ff     <= mag_in;
      fend_ff    <= fend_in;
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      div_cnt_ff <= div_cnt_in;
      word_ff    <= word_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      quo_ff     <= quo_in;
      v_ff       <= v_in;
      acc_ff     <= acc_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_lvl_ff <= rsp_lvl_in;
      rsp_pk_ff  <= rsp_pk_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= 16'd1000;
         noise_gate_ff  <= 16'd0;
         smooth_ff      <= 16'd45875;
         hold_frames_ff <= 8'd30;
         fall_ff        <= 16'd328;
      end else if (csr_we) begin
         case (csr_index)
            lbsp_pkg::CSR_GAIN:       gain_ff        <= csr_wdata;
            lbsp_pkg::CSR_NOISE_GATE: noise_gate_ff  <= csr_wdata;
            lbsp_pkg::CSR_SMOOTH:     smooth_ff      <= csr_wdata;
            lbsp_pkg::CSR_HOLD:       hold_frames_ff <= csr_wdata[lbsp_pkg::HOLD_W-1:0];
            lbsp_pkg::CSR_FALL:       fall_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // checks
   a_last_band_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last_band |-> rsp_bus.band_index == lbsp_pkg::IDX_W'(BANDS - 1))
      else $error("last_band on wrong band");

   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.level <= lbsp_pkg::FULL_SCALE &&
                        rsp_bus.peak_level <= lbsp_pkg::FULL_SCALE)
      else $error("level or peak above full scale");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("item accepted while busy");

endmodule

`default_nettype wire

/* sim/tb_log_band_spectrum_peak_hold.sv */
// Testbench for log_band_spectrum_peak_hold: random bin frames on both channels
// under changing register settings, checked band by band against a built-in predictor.
// Depends on lbsp_pkg, lbsp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_log_band_spectrum_peak_hold;

   localparam int BAND_CNT  = 32;
   localparam int POINTS    = 1024;
   localparam int RATE_HZ   = 44100;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      bit                           chan;
      bit [lbsp_pkg::IDX_W-1:0]     band;
      bit [lbsp_pkg::LVL_W-1:0]     level;
      bit [lbsp_pkg::LVL_W-1:0]     peak;
      bit                           last;
   } band_result_type;

   // Spectrum predictor with its queue of pending band results
   class spectrum_scoreboard;
      band_result_type          pending[$];
      int                       band_of_bin[0:4095];
      bit [63:0]                acc_sum[2][lbsp_pkg::MAX_BANDS];
      int unsigned              acc_cnt[2][lbsp_pkg::MAX_BANDS];
      int unsigned              bin_pos[2];
      bit [lbsp_pkg::LVL_W-1:0] smooth_lvl[2][lbsp_pkg::MAX_BANDS];
      bit [lbsp_pkg::LVL_W-1:0] peak_lvl[2][lbsp_pkg::MAX_BANDS];
      bit [7:0]                 hold_left[2][lbsp_pkg::MAX_BANDS];
      bit [15:0]                gain_r, gate_r, smooth_r, fall_r;
      bit [7:0]                 hold_r;
      int                       errors;

      // Q30 base-2 log by repeated squaring, truncated
      function bit [63:0] log2_fix(bit [31:0] x);
         int        e;
         bit [63:0] m, r;
         if (x == 0) return 0;
         e = 31;
         while (!x[e]) e--;
         m = (e <= 30) ? (64'(x) << (30 - e)) : 64'(x >> (e - 30));
         r = 64'(e) << 30;
         for (int b = 29; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               r[b] = 1'b1;
            end
         end
         return r;
      endfunction

      function new();
         bit [63:0] a, lo, hi, base, q;
         lo   = log2_fix(32'(100 * POINTS));
         hi   = log2_fix(32'(RATE_HZ / 2));
         base = log2_fix(32'd100);
         for (int i = 0; i < 4096; i++) begin
            band_of_bin[i] = -1;
            if (i >= 5 && i < POINTS / 2 && i * RATE_HZ >= 100 * POINTS) begin
               a = log2_fix(32'(i * RATE_HZ));
               if (hi <= base || a <= lo) band_of_bin[i] = 0;
               else begin
                  q = ((a - lo) * BAND_CNT) / (hi - base);
                  band_of_bin[i] = (q >= BAND_CNT) ? BAND_CNT - 1 : int'(q);
               end
            end
         end
         gain_r = 1000; gate_r = 0; smooth_r = 45875; hold_r = 30; fall_r = 328;
         errors = 0;
         for (int c = 0; c < 2; c++) begin
            bin_pos[c] = 0;
            for (int k = 0; k < lbsp_pkg::MAX_BANDS; k++) begin
               acc_sum[c][k] = 0; acc_cnt[c][k] = 0;
               smooth_lvl[c][k] = 0; peak_lvl[c][k] = 0; hold_left[c][k] = 0;
            end
         end
      endfunction

      function void set_reg(bit [lbsp_pkg::CSR_A_W-1:0] idx, bit [15:0] val);
         case (idx)
            lbsp_pkg::CSR_GAIN:       gain_r = val;
            lbsp_pkg::CSR_NOISE_GATE: gate_r = val;
            lbsp_pkg::CSR_SMOOTH:     smooth_r = val;
            lbsp_pkg::CSR_HOLD:       hold_r = val[7:0];
            lbsp_pkg::CSR_FALL:       fall_r = val;
            default: ;
         endcase
      endfunction

      // Accumulate one accepted bin; on frame end, walk the bands
      function void note_bin(bit ch, bit [23:0] mag, bit fend);
         int              b;
         bit [63:0]       v, p, q, s;
         band_result_type r;
         b = band_of_bin[bin_pos[ch]];
         if (b >= 0 && acc_cnt[ch][b] < 1023) begin
            acc_sum[ch][b] += mag;
            acc_cnt[ch][b]++;
         end
         if (bin_pos[ch] < 4095) bin_pos[ch]++;
         if (!fend) return;
         for (int k = 0; k < BAND_CNT; k++) begin
            v = 0;
            if (acc_cnt[ch][k] != 0) begin
               p = acc_sum[ch][k] * gain_r;
               q = 64'(acc_cnt[ch][k]) * 64'd10000000;
               v = (p >= q) ? 64'd32768 : (p * 64'd32768) / q;
            end
            if (v < gate_r) v = 0;
            s = (64'(smooth_lvl[ch][k]) * smooth_r + v * (64'd65536 - smooth_r) + 64'd32768)
                >> 16;
            smooth_lvl[ch][k] = s[15:0];
            if (smooth_lvl[ch][k] > peak_lvl[ch][k]) begin
               peak_lvl[ch][k] = smooth_lvl[ch][k];
               hold_left[ch][k] = hold_r;
            end else if (hold_left[ch][k] > 0) begin
               hold_left[ch][k]--;
            end else if (peak_lvl[ch][k] > fall_r) begin
               peak_lvl[ch][k] -= fall_r;
            end else begin
               peak_lvl[ch][k] = 0;
            end
            r.chan = ch; r.band = lbsp_pkg::IDX_W'(k); r.level = smooth_lvl[ch][k];
            r.peak = peak_lvl[ch][k]; r.last = (k == BAND_CNT - 1);
            pending.push_back(r);
            acc_sum[ch][k] = 0; acc_cnt[ch][k] = 0;
         end
         bin_pos[ch] = 0;
      endfunction

      function void check_result(band_result_type got);
         band_result_type exp_r;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected band result: ch %0d band %0d level %0d peak %0d",
                        got.chan, got.band, got.level, got.peak);
            return;
         end
         exp_r = pending.pop_front();
         if (got != exp_r) begin
            errors++;
            if (errors <= 10)
               $display("band mismatch: expected ch %0d band %0d lvl %0d pk %0d last %0d, %s",
                        exp_r.chan, exp_r.band, exp_r.level, exp_r.peak, exp_r.last,
                        $sformatf("actual ch %0d band %0d lvl %0d pk %0d last %0d",
                                  got.chan, got.band, got.level, got.peak, got.last));
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [lbsp_pkg::CSR_A_W-1:0]  csr_index = '0;
   logic [lbsp_pkg::CSR_D_W-1:0]  csr_wdata = '0;
   bit                            no_gaps = 1'b0;
   int                            idle_cycles = 0;
   spectrum_scoreboard            sb;

   lbsp_req_if req_bus();
   lbsp_rsp_if rsp_bus();

   log_band_spectrum_peak_hold #(
      .BANDS(BAND_CNT), .FFT_POINTS(POINTS), .SAMPLE_RATE_HZ(RATE_HZ)
   ) DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0; req_bus.channel = 1'b0;
      req_bus.magnitude = '0; req_bus.frame_end = 1'b0;
      rsp_bus.ready = 1'b0;
      sb = new();
   end

   // Result monitor and idle watchdog
   always @(posedge clock) begin
      band_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.chan = rsp_bus.out_channel; got.band = rsp_bus.band_index;
         got.level = rsp_bus.level; got.peak = rsp_bus.peak_level;
         got.last = rsp_bus.last_band;
         sb.check_result(got);
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver with random stalls
   initial begin
      int n;
      @(negedge reset);
      @(posedge clock);
      rsp_bus.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!rsp_bus.valid);
         n = no_gaps ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_bin(bit ch, bit [23:0] mag, bit fend);
      int n;
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.channel <= ch;
      req_bus.magnitude <= mag;
      req_bus.frame_end <= fend;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_bin(ch, mag, fend);
   endtask

   task automatic write_reg(bit [lbsp_pkg::CSR_A_W-1:0] idx, bit [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // Wait for the walk to finish and any bin still in flight
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic bit [23:0] rand_mag();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom) & 24'((1 << $urandom_range(1, 24)) - 1);
      endcase
   endfunction

   initial begin
      int items;
      bit ch;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty frame, full-scale and zero bins, short interleaved frames
      no_gaps = 1'b1;
      send_bin(1'b1, 24'hFFFFFF, 1'b1);
      for (int i = 0; i < 10; i++) begin
         send_bin(1'b0, 24'hFFFFFF, 1'b0);
         send_bin(1'b1, (i % 2) ? 24'h000000 : 24'h00A5A5, 1'b0);
      end
      send_bin(1'b0, 24'h5A5A5A, 1'b1);
      send_bin(1'b1, 24'h000001, 1'b1);
      send_bin(1'b0, 24'h000000, 1'b1);
      drain();

      // Phases under different register settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_reg(lbsp_pkg::CSR_GAIN, 16'hFFFF);
               write_reg(lbsp_pkg::CSR_NOISE_GATE, 16'd32768);
               write_reg(lbsp_pkg::CSR_SMOOTH, 16'd0);
               write_reg(lbsp_pkg::CSR_HOLD, 16'd255);
               write_reg(lbsp_pkg::CSR_FALL, 16'd32768);
            end
            1: begin
               write_reg(lbsp_pkg::CSR_GAIN, 16'd0);
               write_reg(lbsp_pkg::CSR_NOISE_GATE, 16'd0);
               write_reg(lbsp_pkg::CSR_SMOOTH, 16'hFFFF);
               write_reg(lbsp_pkg::CSR_HOLD, 16'd0);
               write_reg(lbsp_pkg::CSR_FALL, 16'd0);
            end
            2: begin
               // above-range gate and fall, hold with upper bits set
               write_reg(lbsp_pkg::CSR_GAIN, 16'd1000);
               write_reg(lbsp_pkg::CSR_NOISE_GATE, 16'hFFFF);
               write_reg(lbsp_pkg::CSR_SMOOTH, 16'd1000);
               write_reg(lbsp_pkg::CSR_HOLD, 16'hFF02);
               write_reg(lbsp_pkg::CSR_FALL, 16'hFFFF);
            end
            default: begin
               write_reg(lbsp_pkg::CSR_GAIN, 16'($urandom_range(0, 65535)));
               write_reg(lbsp_pkg::CSR_NOISE_GATE, 16'($urandom_range(0, 4000)));
               write_reg(lbsp_pkg::CSR_SMOOTH, 16'($urandom_range(0, 65535)));
               write_reg(lbsp_pkg::CSR_HOLD, 16'($urandom_range(0, 6)));
               write_reg(lbsp_pkg::CSR_FALL, 16'($urandom_range(0, 3000)));
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);

         items = 0;
         while (items < 32) begin
            ch = $urandom_range(0, 1);
            send_bin(ch, rand_mag(), $urandom_range(0, 15) == 0);
            items++;
         end
         send_bin(1'b0, rand_mag(), 1'b1);
         send_bin(1'b1, rand_mag(), 1'b1);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lbsp_pkg.sv
rtl/lbsp_if.sv
rtl/lbsp_alu.sv
rtl/lbsp_band_mem.sv
rtl/log_band_spectrum_peak_hold.sv
sim/tb_log_band_spectrum_peak_hold.sv
